// ===== rtl/core/ehi_pkg.sv =====
`timescale 1ns / 1ps
package ehi_pkg;

  // default geometry
  localparam int MAX_DEPTH_DEF    = 8;
  localparam int BUCKET_SLOTS_DEF = 2;
  localparam int KEY_WIDTH_DEF    = 32;

  // fixed field widths
  localparam int IN_KEY_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int ID_W       = 8;
  localparam int DEPTH_W    = 4;
  localparam int SPLITS_W   = 4;
  localparam int INIT_DEPTH = 1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIRA,
    ST_DIRW,
    ST_BKT,
    ST_EVAL,
    ST_DOUBLE,
    ST_WR_OLD,
    ST_WR_NEW,
    ST_REPOINT
  } ctrl_state_t;

endpackage

// ===== rtl/core/ehi_channels.sv =====
`timescale 1ns / 1ps
// key input channel
interface ehi_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ehi_pkg::IN_KEY_W-1:0] key;
  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

// result channel
interface ehi_out_if;
  logic                          valid;
  logic                          ready;
  logic [ehi_pkg::STATUS_W-1:0]  status;
  logic [ehi_pkg::ID_W-1:0]      dir_index;
  logic [ehi_pkg::ID_W-1:0]      bucket_id;
  logic [ehi_pkg::DEPTH_W-1:0]   global_depth_now;
  logic [ehi_pkg::SPLITS_W-1:0]  split_count;
  modport source (output valid, output status, output dir_index, output bucket_id,
                  output global_depth_now, output split_count, input ready);
  modport sink (input valid, input status, input dir_index, input bucket_id,
                input global_depth_now, input split_count, output ready);
endinterface

// configuration write channel
interface ehi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ehi_pkg::DEPTH_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/extendible_hash_insert_unit.sv =====
`timescale 1ns / 1ps
// a key moves through the directory address, directory read, bucket read and evaluation states;
// the result is registered in the evaluation state and the next key is taken in idle
// each split adds the old bucket write, new bucket write and pointer repoint pass, then a new lookup,
// plus a directory copy pass when the directory doubles; one key in flight at a time
// a result transaction that is not taken holds the unit in its final lookup cycle
// reset and every configuration write start a clearing pass over all 2^MAX_DEPTH directory entries
module extendible_hash_insert_unit #(
  parameter int MAX_DEPTH    = ehi_pkg::MAX_DEPTH_DEF,
  parameter int BUCKET_SLOTS = ehi_pkg::BUCKET_SLOTS_DEF,
  parameter int KEY_WIDTH    = ehi_pkg::KEY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ehi_in_if.sink     in_chan,
  ehi_out_if.source  out_chan,
  ehi_cfg_if.sink    cfg_chan
);

  localparam int MD       = MAX_DEPTH;
  localparam int DW       = ehi_pkg::DEPTH_W;
  localparam int DIR_SIZE = 1 << MD;
  localparam int FW       = $clog2(BUCKET_SLOTS + 1);
  localparam int SW       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  typedef logic [BUCKET_SLOTS-1:0][KEY_WIDTH-1:0] keys_t;
  typedef struct packed {
    logic [DW-1:0] ld;
    logic [FW-1:0] fill;
  } meta_t;

  // memories
  logic [MD-1:0] dir_mem [DIR_SIZE];
  meta_t         bmeta_mem [DIR_SIZE];
  keys_t         bkeys_mem [DIR_SIZE];

  logic [MD-1:0] dir_q;
  meta_t         bmeta_q;
  keys_t         bkeys_q;

  logic          dir_we;
  logic [MD-1:0] dir_wa, dir_wd, dir_ra;
  logic          bk_we;
  logic [MD-1:0] bk_wa;
  meta_t         bmeta_wd;
  keys_t         bkeys_wd;

  // control state
  ehi_pkg::ctrl_state_t state_r, state_nxt;
  logic [MD:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]   gd_r, gd_nxt;
  logic [MD:0]     nfb_r, nfb_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload state
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [MD-1:0]   idx_r, idx_nxt;
  logic [MD-1:0]   b_r, b_nxt;
  logic [MD-1:0]   nb_r, nb_nxt;
  logic [DW-1:0]   old_r, old_nxt;
  logic [DW-1:0]   splits_r, splits_nxt;
  keys_t           lo_keys_r, lo_keys_nxt, hi_keys_r, hi_keys_nxt;
  logic [FW-1:0]   lo_fill_r, lo_fill_nxt, hi_fill_r, hi_fill_nxt;
  ehi_pkg::status_t out_status_r, out_status_nxt;
  logic [ehi_pkg::ID_W-1:0] out_idx_r, out_idx_nxt, out_bkt_r, out_bkt_nxt;
  logic [DW-1:0]   out_gd_r, out_gd_nxt, out_splits_r, out_splits_nxt;

  // helper terms
  logic            in_acc, cfg_acc, can_out;
  logic [MD:0]     size;
  logic [MD:0]     prev;
  logic [MD:0]     dbl_wa;
  logic [MD-1:0]   cur_idx;
  logic            dup, room, at_limit, grow;
  keys_t           ins_keys, lo_keys_c, hi_keys_c;
  logic [FW-1:0]   lo_n, hi_n;
  logic [DW-1:0]   cfg_sat;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign can_out = !out_valid_r || out_chan.ready;
  assign size    = (MD+1)'(1) << gd_r;
  assign prev    = cnt_r - (MD+1)'(1);
  assign dbl_wa  = size | prev;
  assign cur_idx = key_r[MD-1:0] & ~({MD{1'b1}} << gd_r);
  assign cfg_sat = (cfg_chan.data > DW'(MD)) ? DW'(MD) : cfg_chan.data;

  assign in_chan.ready  = (state_r == ehi_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.dir_index        = out_idx_r;
  assign out_chan.bucket_id        = out_bkt_r;
  assign out_chan.global_depth_now = out_gd_r;
  assign out_chan.split_count      = out_splits_r;

  // bucket evaluation: duplicate search, insert row, split rows
  always_comb begin
    dup       = 1'b0;
    ins_keys  = bkeys_q;
    lo_keys_c = bkeys_q;
    hi_keys_c = bkeys_q;
    lo_n      = '0;
    hi_n      = '0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (FW'(s) < bmeta_q.fill) begin
        if (bkeys_q[s] == key_r) begin
          dup = 1'b1;
        end
        if ((int'(bmeta_q.ld) < KEY_WIDTH) && bkeys_q[s][bmeta_q.ld]) begin
          hi_keys_c[hi_n[SW-1:0]] = bkeys_q[s];
          hi_n = hi_n + FW'(1);
        end else begin
          lo_keys_c[lo_n[SW-1:0]] = bkeys_q[s];
          lo_n = lo_n + FW'(1);
        end
      end
    end
    ins_keys[bmeta_q.fill[SW-1:0]] = key_r;
  end

  assign room     = bmeta_q.fill < FW'(BUCKET_SLOTS);
  assign at_limit = (bmeta_q.ld >= DW'(MD)) || nfb_r[MD];
  assign grow     = ({1'b0, bmeta_q.ld} + (DW+1)'(1)) > {1'b0, gd_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ehi_pkg::ST_CLEAR: begin
        if (cnt_r == (MD+1)'(DIR_SIZE - 1)) state_nxt = ehi_pkg::ST_IDLE;
      end
      ehi_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ehi_pkg::ST_DIRA;
      end
      ehi_pkg::ST_DIRA: state_nxt = ehi_pkg::ST_DIRW;
      ehi_pkg::ST_DIRW: state_nxt = ehi_pkg::ST_BKT;
      ehi_pkg::ST_BKT:  state_nxt = ehi_pkg::ST_EVAL;
      ehi_pkg::ST_EVAL: begin
        if (dup || room || at_limit) begin
          if (can_out) state_nxt = ehi_pkg::ST_IDLE;
        end else if (grow) begin
          state_nxt = ehi_pkg::ST_DOUBLE;
        end else begin
          state_nxt = ehi_pkg::ST_WR_OLD;
        end
      end
      ehi_pkg::ST_DOUBLE: begin
        if (cnt_r == size) state_nxt = ehi_pkg::ST_WR_OLD;
      end
      ehi_pkg::ST_WR_OLD: state_nxt = ehi_pkg::ST_WR_NEW;
      ehi_pkg::ST_WR_NEW: state_nxt = ehi_pkg::ST_REPOINT;
      ehi_pkg::ST_REPOINT: begin
        if (cnt_r == size) state_nxt = ehi_pkg::ST_DIRA;
      end
      default: state_nxt = ehi_pkg::ST_CLEAR;
    endcase
    if (cfg_acc) state_nxt = ehi_pkg::ST_CLEAR;
  end

  // datapath and memory controls
  always_comb begin
    cnt_nxt        = cnt_r;
    gd_nxt         = gd_r;
    nfb_nxt        = nfb_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    b_nxt          = b_r;
    nb_nxt         = nb_r;
    old_nxt        = old_r;
    splits_nxt     = splits_r;
    lo_keys_nxt    = lo_keys_r;
    hi_keys_nxt    = hi_keys_r;
    lo_fill_nxt    = lo_fill_r;
    hi_fill_nxt    = hi_fill_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_bkt_nxt    = out_bkt_r;
    out_gd_nxt     = out_gd_r;
    out_splits_nxt = out_splits_r;
    dir_we   = 1'b0;
    dir_wa   = cnt_r[MD-1:0];
    dir_wd   = '0;
    dir_ra   = cnt_r[MD-1:0];
    bk_we    = 1'b0;
    bk_wa    = b_r;
    bmeta_wd = '0;
    bkeys_wd = ins_keys;
    case (state_r)
      // clear directory, reset bucket 0
      ehi_pkg::ST_CLEAR: begin
        dir_we  = 1'b1;
        cnt_nxt = cnt_r + (MD+1)'(1);
        if (cnt_r == '0) begin
          bk_we = 1'b1;
          bk_wa = '0;
        end
      end
      ehi_pkg::ST_IDLE: begin
        if (in_acc) begin
          key_nxt    = KEY_WIDTH'(in_chan.key);
          splits_nxt = '0;
        end
      end
      ehi_pkg::ST_DIRA: begin
        dir_ra  = cur_idx;
        idx_nxt = cur_idx;
      end
      ehi_pkg::ST_DIRW: b_nxt = dir_q;
      ehi_pkg::ST_BKT: ;
      ehi_pkg::ST_EVAL: begin
        if (dup || room || at_limit) begin
          if (can_out) begin
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = ehi_pkg::ID_W'(idx_r);
            out_bkt_nxt    = ehi_pkg::ID_W'(b_r);
            out_gd_nxt     = gd_r;
            out_splits_nxt = splits_r;
            if (dup) begin
              out_status_nxt = ehi_pkg::STATUS_DUPLICATE;
            end else if (room) begin
              out_status_nxt = ehi_pkg::STATUS_INSERTED;
              bk_we          = 1'b1;
              bmeta_wd.ld    = bmeta_q.ld;
              bmeta_wd.fill  = bmeta_q.fill + FW'(1);
            end else begin
              out_status_nxt = ehi_pkg::STATUS_OVERFLOW;
            end
          end
        end else begin
          old_nxt     = bmeta_q.ld;
          nb_nxt      = nfb_r[MD-1:0];
          lo_keys_nxt = lo_keys_c;
          hi_keys_nxt = hi_keys_c;
          lo_fill_nxt = lo_n;
          hi_fill_nxt = hi_n;
          cnt_nxt     = '0;
        end
      end
      // copy lower half of directory into upper half
      ehi_pkg::ST_DOUBLE: begin
        dir_wa = dbl_wa[MD-1:0];
        dir_wd = dir_q;
        dir_we = (cnt_r != '0);
        if (cnt_r == size) begin
          gd_nxt = gd_r + DW'(1);
        end else begin
          cnt_nxt = cnt_r + (MD+1)'(1);
        end
      end
      ehi_pkg::ST_WR_OLD: begin
        bk_we         = 1'b1;
        bmeta_wd.ld   = old_r + DW'(1);
        bmeta_wd.fill = lo_fill_r;
        bkeys_wd      = lo_keys_r;
      end
      ehi_pkg::ST_WR_NEW: begin
        bk_we         = 1'b1;
        bk_wa         = nb_r;
        bmeta_wd.ld   = old_r + DW'(1);
        bmeta_wd.fill = hi_fill_r;
        bkeys_wd      = hi_keys_r;
        nfb_nxt       = nfb_r + (MD+1)'(1);
        splits_nxt    = splits_r + DW'(1);
        cnt_nxt       = '0;
      end
      // point entries with the split bit set at the new bucket
      ehi_pkg::ST_REPOINT: begin
        dir_wa = prev[MD-1:0];
        dir_wd = nb_r;
        dir_we = (cnt_r != '0) && (dir_q == b_r) && (((prev >> old_r) & (MD+1)'(1)) != '0);
        if (cnt_r != size) cnt_nxt = cnt_r + (MD+1)'(1);
      end
      default: ;
    endcase
    if (cfg_acc) begin
      gd_nxt  = cfg_sat;
      nfb_nxt = (MD+1)'(1);
      cnt_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ehi_pkg::ST_CLEAR;
      cnt_r       <= '0;
      gd_r        <= DW'(ehi_pkg::INIT_DEPTH > MD ? MD : ehi_pkg::INIT_DEPTH);
      nfb_r       <= (MD+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gd_r        <= gd_nxt;
      nfb_r       <= nfb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    b_r          <= b_nxt;
    nb_r         <= nb_nxt;
    old_r        <= old_nxt;
    splits_r     <= splits_nxt;
    lo_keys_r    <= lo_keys_nxt;
    hi_keys_r    <= hi_keys_nxt;
    lo_fill_r    <= lo_fill_nxt;
    hi_fill_r    <= hi_fill_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_bkt_r    <= out_bkt_nxt;
    out_gd_r     <= out_gd_nxt;
    out_splits_r <= out_splits_nxt;
  end

  // directory memory
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_q <= dir_mem[dir_ra];
  end

  // bucket memory, read at the current bucket
  always_ff @(posedge clk) begin
    if (bk_we) begin
      bmeta_mem[bk_wa] <= bmeta_wd;
      bkeys_mem[bk_wa] <= bkeys_wd;
    end
    bmeta_q <= bmeta_mem[b_r];
    bkeys_q <= bkeys_mem[b_r];
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH_LIM = ehi_pkg::MAX_DEPTH_DEF;
  localparam int SLOTS     = ehi_pkg::BUCKET_SLOTS_DEF;
  localparam int NBKT      = 1 << DEPTH_LIM;
  localparam int SETTLE    = 600;

  typedef struct packed {
    ehi_pkg::status_t                 status;
    logic [ehi_pkg::ID_W-1:0]         dir_index;
    logic [ehi_pkg::ID_W-1:0]         bucket_id;
    logic [ehi_pkg::DEPTH_W-1:0]      gdepth;
    logic [ehi_pkg::SPLITS_W-1:0]     splits;
  } insert_result_t;

  logic clk;
  logic rst_n;

  ehi_in_if  in_if ();
  ehi_out_if out_if ();
  ehi_cfg_if cfg_if ();

  extendible_hash_insert_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // shadow hash table
  logic [ehi_pkg::DEPTH_W-1:0]  tbl_gdepth;
  logic [ehi_pkg::ID_W:0]       tbl_dir [NBKT];
  logic [ehi_pkg::DEPTH_W-1:0]  tbl_ldepth [NBKT];
  int                           tbl_fill [NBKT];
  logic [31:0]                  tbl_keys [NBKT][SLOTS];
  int                           tbl_next;

  insert_result_t pending_results[$];
  logic [31:0]    key_history[$];
  int             err_count;
  int             hold_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // limit on run time
  initial begin
    #(64'd500_000_000);
    $display("[extendible_hash_insert_unit] ERROR");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic void table_clear(input int depth);
    tbl_gdepth = (depth > DEPTH_LIM) ? DEPTH_LIM[ehi_pkg::DEPTH_W-1:0] :
                 depth[ehi_pkg::DEPTH_W-1:0];
    for (int i = 0; i < NBKT; i++) begin
      tbl_dir[i] = '0;
      tbl_ldepth[i] = '0;
      tbl_fill[i] = 0;
    end
    tbl_next = 1;
  endfunction

  // split one bucket on bit old of its keys
  function automatic void split_bucket(input int b);
    int old;
    int nb;
    int n;
    int sz;
    int dst;
    logic [31:0] held [SLOTS];
    old = tbl_ldepth[b];
    nb = tbl_next;
    tbl_ldepth[b] = ehi_pkg::DEPTH_W'(old + 1);
    if (old + 1 > tbl_gdepth) begin
      sz = 1 << tbl_gdepth;
      for (int i = 0; i < sz; i++) tbl_dir[sz + i] = tbl_dir[i];
      tbl_gdepth++;
    end
    tbl_next++;
    tbl_ldepth[nb] = ehi_pkg::DEPTH_W'(old + 1);
    tbl_fill[nb] = 0;
    n = tbl_fill[b];
    for (int i = 0; i < SLOTS; i++) held[i] = tbl_keys[b][i];
    tbl_fill[b] = 0;
    for (int i = 0; i < n; i++) begin
      dst = held[i][old] ? nb : b;
      tbl_keys[dst][tbl_fill[dst]] = held[i];
      tbl_fill[dst]++;
    end
    sz = 1 << tbl_gdepth;
    for (int i = 0; i < sz; i++)
      if (tbl_dir[i] == b && ((i >> old) & 1)) tbl_dir[i] = (ehi_pkg::ID_W+1)'(nb);
  endfunction

  function automatic insert_result_t hash_insert(input logic [31:0] k);
    insert_result_t r;
    int idx;
    int b;
    int nsplit;
    bit dup;
    nsplit = 0;
    forever begin
      idx = k & ((1 << tbl_gdepth) - 1);
      b = tbl_dir[idx];
      dup = 1'b0;
      for (int s = 0; s < tbl_fill[b]; s++)
        if (tbl_keys[b][s] == k) dup = 1'b1;
      if (dup) begin
        r.status = ehi_pkg::STATUS_DUPLICATE;
        break;
      end
      if (tbl_fill[b] < SLOTS) begin
        tbl_keys[b][tbl_fill[b]] = k;
        tbl_fill[b]++;
        r.status = ehi_pkg::STATUS_INSERTED;
        break;
      end
      if (tbl_ldepth[b] >= DEPTH_LIM || tbl_next >= NBKT) begin
        r.status = ehi_pkg::STATUS_OVERFLOW;
        break;
      end
      split_bucket(b);
      nsplit++;
    end
    r.dir_index = idx[ehi_pkg::ID_W-1:0];
    r.bucket_id = b[ehi_pkg::ID_W-1:0];
    r.gdepth = tbl_gdepth;
    r.splits = nsplit[ehi_pkg::SPLITS_W-1:0];
    return r;
  endfunction

  // key sender: random gap, then one transaction; valid stays up until the next change
  task automatic send_key(input logic [31:0] k);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.key <= k;
    do @(posedge clk); while (!in_if.ready);
    pending_results.insert(pending_results.size(), hash_insert(k));
    if (key_history.size() >= 64) void'(key_history.pop_front());
    key_history.insert(key_history.size(), k);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_depth(input logic [ehi_pkg::DEPTH_W-1:0] d);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    table_clear(d);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5: k = (key_history.size() != 0) ?
                key_history[$urandom_range(0, key_history.size() - 1)] : $urandom;
      // shared low bits drive deep splits and the depth limit
      6, 7, 8: k = {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00} |
                   32'($urandom_range(0, 15));
      default: k = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 | $urandom_range(0, 7) :
                   32'h7FFF_FFF8 | $urandom_range(0, 7);
    endcase
    return k;
  endfunction

  // result checker
  always @(posedge clk) begin
    insert_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) report("status", out_if.status, want.status);
        if (out_if.dir_index !== want.dir_index)
          report("dir_index", out_if.dir_index, want.dir_index);
        if (out_if.bucket_id !== want.bucket_id)
          report("bucket_id", out_if.bucket_id, want.bucket_id);
        if (out_if.global_depth_now !== want.gdepth)
          report("global_depth_now", out_if.global_depth_now, want.gdepth);
        if (out_if.split_count !== want.splits)
          report("split_count", out_if.split_count, want.splits);
      end
    end
  end

  // result ready: random stalls, with an optional long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else if ($urandom_range(0, 39) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic test_edge_keys();
    send_key(32'h7FFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0001);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
  endtask

  task automatic test_duplicates();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h7FFF_FFFF);
  endtask

  // keys sharing all directory bits split to the limit, then drop
  task automatic test_depth_limit();
    write_depth(4'd1);
    send_key(32'h0000_0100);
    send_key(32'h0000_0200);
    send_key(32'hFFFF_FF00);
    send_key(32'h0000_0300);
    send_key(32'h0000_0200);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 3000;
    repeat (20) send_key(pick_key());
  endtask

  task automatic test_random(input logic [ehi_pkg::DEPTH_W-1:0] d, input int n);
    write_depth(d);
    repeat (n) send_key(pick_key());
  endtask

  initial begin
    err_count = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.key = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    table_clear(ehi_pkg::INIT_DEPTH);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_keys();
    test_duplicates();
    test_depth_limit();
    test_backpressure();
    test_random(4'd0, 200);
    test_random(4'd8, 200);
    test_random(4'd15, 150);
    test_random(4'd3, 200);
    test_random(4'd7, 150);
    test_random(4'd1, 200);

    wait_drained();
    if (err_count == 0) begin
      $display("[extendible_hash_insert_unit] OK");
    end else begin
      $display("[extendible_hash_insert_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ehi_pkg.sv
rtl/core/ehi_channels.sv
rtl/core/extendible_hash_insert_unit.sv
tb/tb.sv
